>>> design/i2cras_pkg.sv
// shared types and constants for the i2c register access sequencer
package i2cras_pkg;

  // default transfer size limit and device address after reset
  localparam int unsigned MAX_BYTES_DEF = 256;
  localparam logic [6:0] DEV_ADDR_RST = 7'd74;

  // request and completion codes on the input channel
  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_DONE = 2'd2;

  // bus engine commands
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ_ACK = 3'd3;
  localparam logic [2:0] CMD_READ_NACK = 3'd4;
  localparam logic [2:0] CMD_STOP = 3'd5;

  // expected bus engine status codes
  localparam logic [7:0] ST_START = 8'h08;
  localparam logic [7:0] ST_DEVW_ACK = 8'h18;
  localparam logic [7:0] ST_DATA_ACK = 8'h28;
  localparam logic [7:0] ST_RSTART = 8'h10;
  localparam logic [7:0] ST_DEVR_ACK = 8'h40;

  // result codes
  localparam logic RES_OK = 1'b0;
  localparam logic RES_BAD_STATUS = 1'b1;

  // input transaction payload
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] reg_address;
    logic [8:0]  byte_count;
    logic [7:0]  bus_status;
    logic [7:0]  read_byte;
    logic [7:0]  write_byte;
  } i2cras_in_t;

  // result transaction payload
  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] command_byte;
    logic [7:0] data_out;
    logic       data_valid;
    logic       transfer_done;
    logic       result_code;
    logic [7:0] fail_status;
  } i2cras_out_t;

endpackage

>>> design/i2c_register_access_sequencer_core.sv
// i2c register access sequencer: top level
//
// drives one i2c register read or write above a byte-level bus engine.
// input channel (in_valid/in_stall/in_data) carries read or write requests
// and completions of the last bus command; each input transaction yields
// exactly one result transaction (out_valid/out_stall/out_data) holding the
// next bus command, any received byte and the transfer outcome.
// a transaction passes the input register, then the result register.
// throughput is one transaction per cycle unless the receiver stalls; the
// phase update is a single pass through the next-state logic between them.
// when the receiver stalls, the result register holds its transaction and
// the input register keeps one more; in_stall rises only when both are full.
// cfg_write_en/cfg_write_data set the 7-bit device address; write it only
// while no transfer is in flight.
// synchronous active-low reset empties both registers, returns the
// sequencer to idle, clears its saved request and loads device address 74.
module i2c_register_access_sequencer_core #(
  parameter int unsigned MAX_BYTES = i2cras_pkg::MAX_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  i2cras_pkg::i2cras_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output i2cras_pkg::i2cras_out_t out_data,
  input  logic                    cfg_write_en,
  input  logic [6:0]              cfg_write_data
);
  import i2cras_pkg::*;

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int CMPW = (CW > 9) ? CW : 9;
  localparam logic [CMPW-1:0] MAX_CMP = CMPW'(MAX_BYTES);

  // phase codes
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_START = 4'd1;
  localparam logic [3:0] PH_DEVW = 4'd2;
  localparam logic [3:0] PH_ALO = 4'd3;
  localparam logic [3:0] PH_AHI = 4'd4;
  localparam logic [3:0] PH_WDATA = 4'd5;
  localparam logic [3:0] PH_RSTART = 4'd6;
  localparam logic [3:0] PH_DEVR = 4'd7;
  localparam logic [3:0] PH_RDATA = 4'd8;

  logic              in_v_r;
  i2cras_in_t        in_r;
  logic              out_v_r;
  i2cras_out_t       out_r;
  i2cras_out_t       out_nxt;
  logic [6:0]        dev_addr_r;
  logic [3:0]        phase_r;
  logic [3:0]        phase_nxt;
  logic              is_read_r;
  logic              is_read_nxt;
  logic [15:0]       saved_addr_r;
  logic [15:0]       saved_addr_nxt;
  logic [CW-1:0]     bytes_left_r;
  logic [CW-1:0]     bytes_left_nxt;
  logic              advance;
  logic [CMPW-1:0]   cnt_ext;
  logic [CMPW-1:0]   cnt_sat;
  logic [CW-1:0]     bl_dec;
  logic [7:0]        exp_status;

  // handshake: input register moves on when the result register frees up
  assign advance = ~out_v_r | ~out_stall;
  assign in_stall = in_v_r & ~advance;
  assign out_valid = out_v_r;
  assign out_data = out_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  // device address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
    end else if (cfg_write_en) begin
      dev_addr_r <= cfg_write_data;
    end
  end

  // request byte count: zero means one, clamp to the limit
  always_comb begin
    cnt_ext = CMPW'(in_r.byte_count);
    if (cnt_ext == '0) begin
      cnt_sat = CMPW'(1);
    end else if (cnt_ext > MAX_CMP) begin
      cnt_sat = MAX_CMP;
    end else begin
      cnt_sat = cnt_ext;
    end
  end

  assign bl_dec = (bytes_left_r != '0) ? bytes_left_r - CW'(1) : bytes_left_r;

  // status each phase expects from the engine
  always_comb begin
    case (phase_r)
      PH_START:  exp_status = ST_START;
      PH_DEVW:   exp_status = ST_DEVW_ACK;
      PH_ALO:    exp_status = ST_DATA_ACK;
      PH_AHI:    exp_status = ST_DATA_ACK;
      PH_WDATA:  exp_status = ST_DATA_ACK;
      PH_RSTART: exp_status = ST_RSTART;
      default:   exp_status = ST_DEVR_ACK;
    endcase
  end

  // sequencer next state and result
  always_comb begin
    phase_nxt = phase_r;
    is_read_nxt = is_read_r;
    saved_addr_nxt = saved_addr_r;
    bytes_left_nxt = bytes_left_r;
    out_nxt = '0;
    out_nxt.bus_command = CMD_NONE;
    out_nxt.result_code = RES_OK;
    if (in_r.operation == OP_READ || in_r.operation == OP_WRITE) begin
      if (phase_r == PH_IDLE) begin
        is_read_nxt = (in_r.operation == OP_READ);
        saved_addr_nxt = in_r.reg_address;
        bytes_left_nxt = CW'(cnt_sat);
        phase_nxt = PH_START;
        out_nxt.bus_command = CMD_START;
      end
    end else if (in_r.operation == OP_DONE && phase_r != PH_IDLE) begin
      if (phase_r == PH_RDATA) begin
        // read data arrives unchecked
        bytes_left_nxt = bl_dec;
        out_nxt.data_out = in_r.read_byte;
        out_nxt.data_valid = 1'b1;
        if (bl_dec != '0) begin
          out_nxt.bus_command = (bl_dec > CW'(1)) ? CMD_READ_ACK : CMD_READ_NACK;
        end else begin
          phase_nxt = PH_IDLE;
          out_nxt.bus_command = CMD_STOP;
          out_nxt.transfer_done = 1'b1;
        end
      end else if (in_r.bus_status != exp_status) begin
        // bad status: finish with error, no stop
        phase_nxt = PH_IDLE;
        out_nxt.transfer_done = 1'b1;
        out_nxt.result_code = RES_BAD_STATUS;
        out_nxt.fail_status = in_r.bus_status;
      end else begin
        case (phase_r)
          PH_START: begin
            phase_nxt = PH_DEVW;
            out_nxt.bus_command = CMD_WRITE;
            out_nxt.command_byte = {dev_addr_r, 1'b0};
          end
          PH_DEVW: begin
            phase_nxt = PH_ALO;
            out_nxt.bus_command = CMD_WRITE;
            out_nxt.command_byte = saved_addr_r[7:0];
          end
          PH_ALO: begin
            phase_nxt = PH_AHI;
            out_nxt.bus_command = CMD_WRITE;
            out_nxt.command_byte = saved_addr_r[15:8];
          end
          PH_AHI, PH_WDATA: begin
            if (phase_r == PH_AHI && is_read_r) begin
              phase_nxt = PH_RSTART;
              out_nxt.bus_command = CMD_START;
            end else if (bytes_left_r != '0) begin
              phase_nxt = PH_WDATA;
              bytes_left_nxt = bl_dec;
              out_nxt.bus_command = CMD_WRITE;
              out_nxt.command_byte = in_r.write_byte;
            end else begin
              phase_nxt = PH_IDLE;
              out_nxt.bus_command = CMD_STOP;
              out_nxt.transfer_done = 1'b1;
            end
          end
          PH_RSTART: begin
            phase_nxt = PH_DEVR;
            out_nxt.bus_command = CMD_WRITE;
            out_nxt.command_byte = {dev_addr_r, 1'b1};
          end
          PH_DEVR: begin
            phase_nxt = PH_RDATA;
            out_nxt.bus_command = (bytes_left_r > CW'(1)) ? CMD_READ_ACK : CMD_READ_NACK;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // sequencer state, updated once per processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      is_read_r <= 1'b0;
      saved_addr_r <= '0;
      bytes_left_r <= '0;
    end else if (in_v_r && advance) begin
      phase_r <= phase_nxt;
      is_read_r <= is_read_nxt;
      saved_addr_r <= saved_addr_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v_r) begin
      out_r <= out_nxt;
    end
  end

endmodule
